// ===== design/drc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the dual RC pulse conditioner.
package drc_pkg;

  localparam int PULSE_BITS_DEF = 12;
  localparam int AGE_BITS_DEF   = 11;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int LIM_W     = 12;
  localparam int FRAC_BITS = 15;

  typedef enum logic [1:0] {
    CMD_PULSE  = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_ARM    = 2'd2,
    CMD_DISARM = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_RANGE       = 3'd1,
    STAT_LOST        = 3'd2,
    STAT_NOT_READY   = 3'd3,
    STAT_MAIN_ARMED  = 3'd4,
    STAT_DISARM_REQ  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_DEADZONE   = 3'd0,
    REG_TIMEOUT    = 3'd1,
    REG_REVERSE    = 3'd2,
    REG_THR_LIMITS = 3'd3,
    REG_THR_CENTER = 3'd4,
    REG_STR_LIMITS = 3'd5,
    REG_STR_CENTER = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_NORM,
    S_DIV,
    S_MUL_THR,
    S_MUL_STR,
    S_FIN
  } state_e;

  // register resets
  localparam logic [7:0]  DZ_RST      = 8'd30;
  localparam logic [9:0]  TMO_RST     = 10'd100;
  localparam logic [1:0]  REV_RST     = 2'd0;
  localparam logic [23:0] LIMITS_RST  = 24'd7783500;  // 1100..1900 us
  localparam logic [11:0] CENTER_RST  = 12'd1500;

  // clamps and scale factors
  localparam logic [7:0]  DZ_MAX      = 8'd200;
  localparam logic [9:0]  TMO_MIN     = 10'd20;
  localparam logic [9:0]  TMO_MAX     = 10'd1000;
  localparam logic [13:0] K_THR       = 14'd10000;
  localparam logic [13:0] K_STR       = 14'd4500;
  localparam logic [14:0] NORM_MAX    = 15'd32767;
  localparam logic [28:0] ROUND_HALF  = 29'd16384;

endpackage

// ===== design/drc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pulse items and result items.
interface drc_in_if #(
  parameter int PULSE_BITS = drc_pkg::PULSE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic                  channel_sel;
  logic [PULSE_BITS-1:0] pulse_us;
  logic                  force_arm;
  logic                  main_armed;

  modport source (output valid, cmd, channel_sel, pulse_us, force_arm, main_armed,
                  input ready);
  modport sink   (input valid, cmd, channel_sel, pulse_us, force_arm, main_armed,
                  output ready);
endinterface

interface drc_out_if;
  logic               valid;
  logic               ready;
  logic               armed_now;
  logic               inputs_ready;
  logic               drive_valid;
  logic signed [14:0] throttle_drive;
  logic signed [13:0] steering_drive;
  logic               main_disarm_request;
  logic [2:0]         status_code;

  modport source (output valid, armed_now, inputs_ready, drive_valid, throttle_drive,
                  steering_drive, main_disarm_request, status_code,
                  input ready);
  modport sink   (input valid, armed_now, inputs_ready, drive_valid, throttle_drive,
                  steering_drive, main_disarm_request, status_code,
                  output ready);
endinterface

// ===== design/dual_rc_pulse_conditioner_arm.sv =====
`timescale 1ns / 1ps
// Top level: two-channel RC pulse conditioner with arming and failsafe.
//
//  channel   dir   handshake      payload
//  in_i      in    valid/ready    cmd, channel_sel, pulse_us, force_arm, main_armed
//  res_o     out   valid/ready    armed_now .. status_code, one item per input item
//  cfg       in    cfg_we_i       cfg_idx_i selects register, cfg_wdata_i (24 bit)
//
// A tick, arm or disarm item passes PREP, MUL_THR, MUL_STR and FIN to res_o;
// an in-range pulse adds a normalize step and, unless it lands in the deadzone
// or saturates, 15 restoring-divider steps, one quotient bit each.
// in_i is ready only in idle, so a new item waits until the last one leaves FIN.
// One shared 15x14 multiplier scales both drive values in two steps.
// Reset (async, active low) clears the state and loads the register defaults.
// A finished result sits in the output register; the block takes the next
// item meanwhile and holds its own result in the final step until res_o drains.
module dual_rc_pulse_conditioner_arm #(
  parameter int PULSE_BITS = drc_pkg::PULSE_BITS_DEF,
  parameter int AGE_BITS   = drc_pkg::AGE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [drc_pkg::CFG_W-1:0]     cfg_wdata_i,
  drc_in_if.sink                        in_i,
  drc_out_if.source                     res_o
);

  // compare width for pulse vs. 12-bit limits, signed width for deltas
  localparam int CW = (PULSE_BITS > drc_pkg::LIM_W) ? PULSE_BITS : drc_pkg::LIM_W;
  localparam int NW = CW + 2;
  localparam logic signed [NW-1:0] ONE_S = NW'(1);

  drc_pkg::state_e state_q, state_d;

  // configuration
  logic [7:0]  dz_cfg_q;
  logic [9:0]  tmo_cfg_q;
  logic [1:0]  rev_q;
  logic [23:0] thr_lim_q, str_lim_q;
  logic [11:0] thr_ctr_q, str_ctr_q;

  // latched item
  drc_pkg::cmd_e         cmd_q;
  logic                  ch_q;
  logic [PULSE_BITS-1:0] pulse_q;
  logic                  force_q;
  logic                  main_q;

  // block state
  logic [AGE_BITS-1:0] age_q [2];
  logic [1:0]          seen_q;
  logic signed [15:0]  norm_q [2];
  logic                arm_q;

  // staged result
  logic               res_arm_q, res_ready_q, res_drive_q, res_req_q;
  drc_pkg::status_e   res_status_q;
  logic signed [14:0] thr_q;
  logic signed [13:0] str_q;

  // output register
  logic               o_valid_q;
  logic               o_arm_q, o_ready_q, o_drive_q, o_req_q;
  drc_pkg::status_e   o_status_q;
  logic signed [14:0] o_thr_q;
  logic signed [13:0] o_str_q;

  // divider
  logic [11:0] den_q, rem_q;
  logic [14:0] quo_q;
  logic [3:0]  cnt_q;
  logic        sign_q;

  // control strobes
  logic in_take, out_free, ld_out;

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_cfg_q  <= drc_pkg::DZ_RST;
      tmo_cfg_q <= drc_pkg::TMO_RST;
      rev_q     <= drc_pkg::REV_RST;
      thr_lim_q <= drc_pkg::LIMITS_RST;
      thr_ctr_q <= drc_pkg::CENTER_RST;
      str_lim_q <= drc_pkg::LIMITS_RST;
      str_ctr_q <= drc_pkg::CENTER_RST;
    end else if (cfg_we_i) begin
      unique case (drc_pkg::reg_idx_e'(cfg_idx_i))
        drc_pkg::REG_DEADZONE:   dz_cfg_q  <= cfg_wdata_i[7:0];
        drc_pkg::REG_TIMEOUT:    tmo_cfg_q <= cfg_wdata_i[9:0];
        drc_pkg::REG_REVERSE:    rev_q     <= cfg_wdata_i[1:0];
        drc_pkg::REG_THR_LIMITS: thr_lim_q <= cfg_wdata_i[23:0];
        drc_pkg::REG_THR_CENTER: thr_ctr_q <= cfg_wdata_i[11:0];
        drc_pkg::REG_STR_LIMITS: str_lim_q <= cfg_wdata_i[23:0];
        drc_pkg::REG_STR_CENTER: str_ctr_q <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Channel selection and clamped settings
  // ---------------------------------------------------------------------------
  logic [23:0] lim;
  logic [11:0] lo, hi, trim;
  logic [7:0]  dz;
  logic [9:0]  tmo;
  logic [CW-1:0] pulse_x;
  logic        in_rng;

  assign lim     = ch_q ? str_lim_q : thr_lim_q;
  assign lo      = lim[11:0];
  assign hi      = lim[23:12];
  assign trim    = ch_q ? str_ctr_q : thr_ctr_q;
  assign dz      = (dz_cfg_q > drc_pkg::DZ_MAX) ? drc_pkg::DZ_MAX : dz_cfg_q;
  assign tmo     = (tmo_cfg_q < drc_pkg::TMO_MIN) ? drc_pkg::TMO_MIN :
                   (tmo_cfg_q > drc_pkg::TMO_MAX) ? drc_pkg::TMO_MAX : tmo_cfg_q;
  assign pulse_x = CW'(pulse_q);
  assign in_rng  = (pulse_x >= CW'(lo)) && (pulse_x <= CW'(hi));

  // ---------------------------------------------------------------------------
  // Age / seen update and arming decision (PREP step)
  // ---------------------------------------------------------------------------
  logic [AGE_BITS-1:0] age_n [2];
  logic [AGE_BITS-1:0] tmo_x;
  logic [1:0]          seen_n;
  logic                ready_n, arm_n, req_n, drive_n;
  drc_pkg::status_e    status_n;

  assign tmo_x = AGE_BITS'(tmo);

  always_comb begin
    age_n[0] = age_q[0];
    age_n[1] = age_q[1];
    seen_n   = seen_q;
    if (cmd_q == drc_pkg::CMD_PULSE && in_rng) begin
      age_n[ch_q]  = '0;
      seen_n[ch_q] = 1'b1;
    end else if (cmd_q == drc_pkg::CMD_TICK) begin
      for (int k = 0; k < 2; k++) begin
        if (age_q[k] != '1) age_n[k] = age_q[k] + 1'b1;
      end
    end
  end

  assign ready_n = seen_n[0] && seen_n[1] && (age_n[0] <= tmo_x) && (age_n[1] <= tmo_x);

  always_comb begin
    arm_n    = arm_q;
    req_n    = 1'b0;
    status_n = drc_pkg::STAT_OK;
    unique case (cmd_q) inside
      drc_pkg::CMD_PULSE, drc_pkg::CMD_TICK: begin
        if (cmd_q == drc_pkg::CMD_PULSE && !in_rng) status_n = drc_pkg::STAT_RANGE;
        // failsafe overrides the range code
        if (arm_q) begin
          if (!ready_n) begin
            arm_n    = 1'b0;
            status_n = drc_pkg::STAT_LOST;
          end else if (main_q) begin
            arm_n    = 1'b0;
            status_n = drc_pkg::STAT_MAIN_ARMED;
          end
        end
      end
      drc_pkg::CMD_ARM: begin
        if (!arm_q) begin
          if (!ready_n) begin
            status_n = drc_pkg::STAT_NOT_READY;
          end else if (main_q) begin
            req_n    = force_q;
            status_n = force_q ? drc_pkg::STAT_DISARM_REQ : drc_pkg::STAT_MAIN_ARMED;
          end else begin
            arm_n = 1'b1;
          end
        end
      end
      drc_pkg::CMD_DISARM: arm_n = 1'b0;
      default: ;
    endcase
  end

  assign drive_n = arm_n && !main_q && ready_n;

  // ---------------------------------------------------------------------------
  // Normalize setup (NORM step): deadzone, numerator, divisor, saturation
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] p_s, trim_s, dz_s, lo_s, hi_s, delta, num_s, den_s;
  logic [11:0]          den_c;
  logic                 is_pos, is_neg, sat, sgn_n;

  assign p_s    = signed'({2'b00, pulse_x});
  assign trim_s = signed'(NW'(trim));
  assign dz_s   = signed'(NW'(dz));
  assign lo_s   = signed'(NW'(lo));
  assign hi_s   = signed'(NW'(hi));
  assign delta  = p_s - trim_s;
  assign is_pos = delta > dz_s;
  assign is_neg = delta < -dz_s;
  assign num_s  = is_pos ? (delta - dz_s) : (-delta - dz_s);
  assign den_s  = is_pos ? (hi_s - trim_s - dz_s) : (trim_s - lo_s - dz_s);
  assign den_c  = (den_s < ONE_S) ? 12'd1 : den_s[11:0];
  // num >= den means the quotient reaches +1
  assign sat    = num_s >= signed'(NW'(den_c));
  assign sgn_n  = is_neg ^ rev_q[ch_q];

  // ---------------------------------------------------------------------------
  // Restoring divider step: (num * 2^15 + den/2) / den, one bit per cycle
  // ---------------------------------------------------------------------------
  logic [14:0] half_den;
  logic [12:0] rem_sh, rem_diff;
  logic        div_ge;
  logic [14:0] quo_n;
  logic signed [15:0] quo_s;

  assign half_den = {4'b0000, den_q[11:1]};
  assign rem_sh   = {rem_q, half_den[cnt_q]};
  assign div_ge   = rem_sh >= {1'b0, den_q};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign quo_n    = {quo_q[13:0], div_ge};
  assign quo_s    = signed'({1'b0, quo_n});

  // ---------------------------------------------------------------------------
  // Shared scaling multiplier
  // ---------------------------------------------------------------------------
  logic               mul_sel;
  logic signed [15:0] nv, nv_neg;
  logic [14:0]        mag;
  logic [13:0]        k_mul;
  logic [28:0]        prod, prod_rnd;
  logic signed [14:0] r_s, drv;

  assign mul_sel  = (state_q == drc_pkg::S_MUL_STR);
  assign nv       = norm_q[mul_sel];
  assign nv_neg   = -nv;
  assign mag      = nv[15] ? nv_neg[14:0] : nv[14:0];
  assign k_mul    = mul_sel ? drc_pkg::K_STR : drc_pkg::K_THR;
  assign prod     = 29'(mag) * 29'(k_mul);
  assign prod_rnd = prod + drc_pkg::ROUND_HALF;
  assign r_s      = signed'({1'b0, prod_rnd[28:drc_pkg::FRAC_BITS]});
  assign drv      = nv[15] ? -r_s : r_s;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drc_pkg::S_IDLE:    if (in_take) state_d = drc_pkg::S_PREP;
      drc_pkg::S_PREP: begin
        state_d = (cmd_q == drc_pkg::CMD_PULSE && in_rng) ? drc_pkg::S_NORM
                                                          : drc_pkg::S_MUL_THR;
      end
      drc_pkg::S_NORM: begin
        state_d = ((!is_pos && !is_neg) || sat) ? drc_pkg::S_MUL_THR : drc_pkg::S_DIV;
      end
      drc_pkg::S_DIV:     if (cnt_q == 4'd0) state_d = drc_pkg::S_MUL_THR;
      drc_pkg::S_MUL_THR: state_d = drc_pkg::S_MUL_STR;
      drc_pkg::S_MUL_STR: state_d = drc_pkg::S_FIN;
      drc_pkg::S_FIN:     if (out_free) state_d = drc_pkg::S_IDLE;
      default:            state_d = drc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == drc_pkg::S_IDLE);
    in_take    = in_i.valid && (state_q == drc_pkg::S_IDLE);
    out_free   = !o_valid_q || res_o.ready;
    ld_out     = (state_q == drc_pkg::S_FIN) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= drc_pkg::S_IDLE;
      age_q[0]  <= '0;
      age_q[1]  <= '0;
      seen_q    <= '0;
      norm_q[0] <= '0;
      norm_q[1] <= '0;
      arm_q     <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == drc_pkg::S_PREP) begin
        age_q[0] <= age_n[0];
        age_q[1] <= age_n[1];
        seen_q   <= seen_n;
        arm_q    <= arm_n;
      end
      if (state_q == drc_pkg::S_NORM) begin
        if (!is_pos && !is_neg) begin
          norm_q[ch_q] <= '0;
        end else if (sat) begin
          norm_q[ch_q] <= sgn_n ? -signed'({1'b0, drc_pkg::NORM_MAX})
                                :  signed'({1'b0, drc_pkg::NORM_MAX});
        end
      end
      if (state_q == drc_pkg::S_DIV && cnt_q == 4'd0) begin
        norm_q[ch_q] <= sign_q ? -quo_s : quo_s;
      end
      if (ld_out) begin
        o_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= drc_pkg::cmd_e'(in_i.cmd);
      ch_q    <= in_i.channel_sel;
      pulse_q <= PULSE_BITS'(in_i.pulse_us);
      force_q <= in_i.force_arm;
      main_q  <= in_i.main_armed;
    end
    if (state_q == drc_pkg::S_PREP) begin
      res_arm_q    <= arm_n;
      res_ready_q  <= ready_n;
      res_drive_q  <= drive_n;
      res_req_q    <= req_n;
      res_status_q <= status_n;
    end
    if (state_q == drc_pkg::S_NORM) begin
      rem_q  <= num_s[11:0];
      den_q  <= den_c;
      sign_q <= sgn_n;
      quo_q  <= '0;
      cnt_q  <= 4'd14;
    end
    if (state_q == drc_pkg::S_DIV) begin
      rem_q <= div_ge ? rem_diff[11:0] : rem_sh[11:0];
      quo_q <= quo_n;
      cnt_q <= cnt_q - 4'd1;
    end
    if (state_q == drc_pkg::S_MUL_THR) thr_q <= res_drive_q ? drv : '0;
    if (state_q == drc_pkg::S_MUL_STR) str_q <= res_drive_q ? drv[13:0] : '0;
    if (ld_out) begin
      o_arm_q    <= res_arm_q;
      o_ready_q  <= res_ready_q;
      o_drive_q  <= res_drive_q;
      o_req_q    <= res_req_q;
      o_status_q <= res_status_q;
      o_thr_q    <= thr_q;
      o_str_q    <= str_q;
    end
  end

  assign res_o.valid               = o_valid_q;
  assign res_o.armed_now           = o_arm_q;
  assign res_o.inputs_ready        = o_ready_q;
  assign res_o.drive_valid         = o_drive_q;
  assign res_o.throttle_drive      = o_thr_q;
  assign res_o.steering_drive      = o_str_q;
  assign res_o.main_disarm_request = o_req_q;
  assign res_o.status_code         = o_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_drive_needs_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.drive_valid |-> res_o.armed_now && res_o.inputs_ready)
    else $error("drive_valid without arm and ready");

  a_idle_drive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.drive_valid |->
      res_o.throttle_drive == '0 && res_o.steering_drive == '0)
    else $error("nonzero drive while not driving");

  a_req_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.main_disarm_request ==
      (res_o.status_code == drc_pkg::STAT_DISARM_REQ))
    else $error("disarm request and status disagree");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == drc_pkg::S_DIV && cnt_q == 4'd0 |=> state_q == drc_pkg::S_MUL_THR)
    else $error("divider overran");

  a_take_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == drc_pkg::S_PREP && !in_i.ready)
    else $error("accepted item not started");

endmodule
